// ===== rtl/b2da_pkg.sv =====
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared constants and types for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package b2da_pkg;

  localparam int VALUE_WIDTH  = 64;
  localparam int MAX_DIGITS   = 20;
  localparam int BCD_WIDTH    = MAX_DIGITS * 4;
  localparam int CNT_WIDTH    = $clog2(VALUE_WIDTH + 1);
  localparam int IDX_WIDTH    = $clog2(MAX_DIGITS);
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_WIDTH   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [5:0] ASCII_ZERO   = 6'd48;
  localparam logic [3:0] DECIMAL_MAX  = 4'd9;
  localparam logic [3:0] DECIMAL_BASE = 4'd10;

  typedef struct packed {
    logic [BCD_WIDTH-1:0] bcd;
  } b2da_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } b2da_qstat_t;

endpackage

// ===== rtl/b2da_front.sv =====
// ----------------------------------------------------------------------------
// b2da_front
// Accepts a value and converts it to packed BCD, one double-dabble step a cycle.
// ----------------------------------------------------------------------------
module b2da_front import b2da_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [63:0]           in_value,
  output logic                  busy,
  input  b2da_qstat_t           q_stat,
  output logic                  push,
  output b2da_entry_t           push_entry
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_PUSH
  } state_t;

  state_t                 state_r;
  logic [VALUE_WIDTH-1:0] work_r;
  logic [BCD_WIDTH-1:0]   bcd_r;
  logic [BCD_WIDTH-1:0]   bcd_nxt;
  logic [CNT_WIDTH-1:0]   cnt_r;

  always_comb begin
    logic [3:0] dig;
    logic       carry;
    carry   = work_r[VALUE_WIDTH-1];
    bcd_nxt = '0;
    for (int d = 0; d < MAX_DIGITS; d++) begin
      dig = bcd_r[d*4 +: 4];
      if (dig >= 4'd5) begin
        dig = dig + 4'd3;
      end
      bcd_nxt[d*4 +: 4] = {dig[2:0], carry};
      carry = dig[3];
    end
  end

  assign busy            = (state_r != ST_IDLE);
  assign push            = (state_r == ST_PUSH) && !q_stat.full;
  assign push_entry.bcd  = bcd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            work_r  <= in_value[VALUE_WIDTH-1:0];
            bcd_r   <= '0;
            cnt_r   <= '0;
            state_r <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          bcd_r  <= bcd_nxt;
          work_r <= {work_r[VALUE_WIDTH-2:0], 1'b0};
          cnt_r  <= cnt_r + 1'b1;
          if (cnt_r == CNT_WIDTH'(VALUE_WIDTH - 1)) begin
            state_r <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (!q_stat.full) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/b2da_queue.sv =====
// ----------------------------------------------------------------------------
// b2da_queue
// Short register queue that holds converted BCD words between front and back.
// ----------------------------------------------------------------------------
module b2da_queue import b2da_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  b2da_entry_t  push_entry,
  input  logic         pop,
  output b2da_entry_t  pop_entry,
  output b2da_qstat_t  q_stat
);

  b2da_entry_t           entry_r [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0] wr_ptr_r;
  logic [QPTR_WIDTH-1:0] rd_ptr_r;
  logic [QCNT_WIDTH-1:0] cnt_r;

  function automatic logic [QPTR_WIDTH-1:0] ptr_inc(input logic [QPTR_WIDTH-1:0] p);
    if (p == QPTR_WIDTH'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign q_stat.full  = (cnt_r == QCNT_WIDTH'(QUEUE_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign pop_entry    = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/b2da_back.sv =====
// ----------------------------------------------------------------------------
// b2da_back
// Skips leading zero digits and emits the rest as ASCII, one word a cycle.
// ----------------------------------------------------------------------------
module b2da_back import b2da_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  b2da_qstat_t  q_stat,
  input  b2da_entry_t  pop_entry,
  output logic         pop,
  output logic         out_valid,
  output logic [5:0]   out_digit_char,
  output logic         out_last_digit
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  state_t                state_r;
  logic [BCD_WIDTH-1:0]  digits_r;
  logic [IDX_WIDTH-1:0]  idx_r;
  logic                  out_valid_r;
  logic [5:0]            out_digit_char_r;
  logic                  out_last_digit_r;
  logic [3:0]            top_dig;
  logic [3:0]            emit_dig;

  assign top_dig  = digits_r[BCD_WIDTH-1 -: 4];
  assign emit_dig = (top_dig >= DECIMAL_BASE) ? DECIMAL_MAX : top_dig;
  assign pop      = (state_r == ST_IDLE) && !q_stat.empty;

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_digit_char_r;
  assign out_last_digit = out_last_digit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (!q_stat.empty) begin
            digits_r <= pop_entry.bcd;
            idx_r    <= IDX_WIDTH'(MAX_DIGITS - 1);
            state_r  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if ((top_dig != 4'd0) || (idx_r == '0)) begin
            state_r <= ST_EMIT;
          end else begin
            digits_r <= {digits_r[BCD_WIDTH-5:0], 4'd0};
            idx_r    <= idx_r - 1'b1;
          end
        end
        ST_EMIT: begin
          out_valid_r      <= 1'b1;
          out_digit_char_r <= ASCII_ZERO + {2'b00, emit_dig};
          out_last_digit_r <= (idx_r == '0);
          digits_r         <= {digits_r[BCD_WIDTH-5:0], 4'd0};
          if (idx_r == '0) begin
            state_r <= ST_IDLE;
          end else begin
            idx_r <= idx_r - 1'b1;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/binary_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Converts a 64-bit unsigned value to decimal ASCII digits, most significant
// first, without leading zeros.
//
//   Channel  Handshake              Words
//   input    start, busy            in_value
//   result   out_valid (strobe)     out_digit_char, out_last_digit
//
// The front loads a value, runs the double-dabble shift steps of the BCD
// register, one per input bit, then hands the word to the queue, waiting while it is full.
// The back scans and emits a value's digits in less time than the front's
// shift loop takes, so that loop sets the sustained rate of values.
// Reset is synchronous and active low and empties the queue.
// Results cannot be held off; the back emits one word per cycle of a run.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii import b2da_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] in_value,
  output logic        busy,
  output logic        out_valid,
  output logic [5:0]  out_digit_char,
  output logic        out_last_digit
);

  b2da_qstat_t q_stat;
  b2da_entry_t push_entry;
  b2da_entry_t pop_entry;
  logic        push;
  logic        pop;

  b2da_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_value   (in_value),
    .busy       (busy),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  b2da_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .q_stat     (q_stat)
  );

  b2da_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .pop_entry      (pop_entry),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit)
  );

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the binary to decimal ASCII converter. Each
// accepted value is run through a bit-serial shift-and-add-3 conversion of
// its own, and the digit words that the block emits are compared in order
// with those expected. Values cover zero, digit-count boundaries, powers of
// ten, full-width extremes and random lengths, under random sender gaps.
// ----------------------------------------------------------------------------
module tb import b2da_pkg::*; ();

  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_ITEMS = 300;
  localparam int TAIL_CYCLES  = 150;

  typedef struct {
    logic [5:0] digit_char;
    logic       last_digit;
  } digit_word_t;

  class digit_scoreboard;
    digit_word_t expected_digits[$];
    int          mismatches;
    int          digits_checked;

    function new();
      mismatches     = 0;
      digits_checked = 0;
    endfunction

    task report_mismatch(input string what);
      $display("mismatch: %s", what);
      mismatches++;
    endtask

    // Converts a value with a BCD shift register and queues its digits.
    function void note_value(input logic [63:0] value);
      logic [63:0] work;
      int          bcd [MAX_DIGITS];
      int          carry;
      int          adj;
      int          top;
      digit_word_t word;
      work = value;
      if (VALUE_WIDTH < 64) begin
        work = value & ((64'd1 << VALUE_WIDTH) - 64'd1);
      end
      foreach (bcd[d]) bcd[d] = 0;
      for (int i = 0; i < VALUE_WIDTH; i++) begin
        carry = work[VALUE_WIDTH-1];
        work  = work << 1;
        for (int d = 0; d < MAX_DIGITS; d++) begin
          adj = bcd[d];
          if (adj >= 5) adj += 3;
          adj    = ((adj << 1) | carry) & 31;
          carry  = adj >> 4;
          bcd[d] = adj & 15;
        end
      end
      top = 0;
      for (int d = MAX_DIGITS - 1; d > 0; d--) begin
        if (bcd[d] != 0) begin
          top = d;
          break;
        end
      end
      for (int d = top; d >= 0; d--) begin
        adj = bcd[d];
        if (adj >= DECIMAL_BASE) adj = DECIMAL_MAX;
        word.digit_char = ASCII_ZERO + 6'(adj);
        word.last_digit = (d == 0);
        expected_digits.push_back(word);
      end
    endfunction

    task check_digit(input logic [5:0] digit_char, input logic last_digit);
      digit_word_t want;
      if (expected_digits.size() == 0) begin
        report_mismatch($sformatf("unexpected digit word %0d last %0b",
                                  digit_char, last_digit));
      end else begin
        want = expected_digits.pop_front();
        digits_checked++;
        if (digit_char !== want.digit_char) begin
          report_mismatch($sformatf("digit_char %0d, expected %0d",
                                    digit_char, want.digit_char));
        end
        if (last_digit !== want.last_digit) begin
          report_mismatch($sformatf("last_digit %0b, expected %0b",
                                    last_digit, want.last_digit));
        end
      end
    endtask

    function int pending();
      return expected_digits.size();
    endfunction
  endclass

  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        start    = 1'b0;
  logic [63:0] in_value = 64'd0;
  logic        busy;
  logic        out_valid;
  logic [5:0]  out_digit_char;
  logic        out_last_digit;

  digit_scoreboard sb = new();
  int              values_sent = 0;
  int              cycles      = 0;
  bit              steady      = 1'b0;

  binary_to_decimal_ascii u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_value      (in_value),
    .busy          (busy),
    .out_valid     (out_valid),
    .out_digit_char(out_digit_char),
    .out_last_digit(out_last_digit)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d digit words outstanding", sb.pending());
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_digit(out_digit_char, out_last_digit);
    end
  end

  task send_value(input logic [63:0] value, input bit pause);
    in_value <= value;
    start    <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_value(value);
    values_sent++;
    if (pause || (!steady && $urandom_range(0, 99) < 34)) begin
      start <= 1'b0;
      if (pause) begin
        do @(posedge clk); while (sb.pending() != 0);
      end else if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(13, 100)) @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  function automatic logic [63:0] power_of_ten(input int exponent);
    logic [63:0] p;
    p = 64'd1;
    repeat (exponent) p = p * 64'd10;
    return p;
  endfunction

  initial begin
    logic [63:0] directed [$];
    logic [63:0] value;
    directed = '{64'd0, 64'd1, 64'd9, 64'd10, 64'd11, 64'd99, 64'd100, 64'd255,
                 64'd1000, 64'd65535, 64'hFFFF_FFFF, 64'h1_0000_0000,
                 64'd1000000000000000000, 64'd9999999999999999999,
                 64'd10000000000000000000, 64'h8000_0000_0000_0000,
                 64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFF,
                 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                 64'd12345678901234567890, 64'd9876543210};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      send_value(directed[i], i == directed.size() - 1);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 100 && n < 180);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: value = {$urandom, $urandom};
        4, 5, 6, 7: value = {$urandom, $urandom} >> $urandom_range(1, 63);
        8: begin
          value = power_of_ten($urandom_range(0, 19));
          case ($urandom_range(0, 2))
            0: value = value - 64'd1;
            1: value = value + 64'd1;
            default: ;
          endcase
        end
        default: value = 64'($urandom_range(0, 999));
      endcase
      send_value(value, n == 240 || n == RANDOM_ITEMS - 1);
    end

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("converted %0d values into %0d digit words, including zero,",
             values_sent, sb.digits_checked);
    $display("full-width and power-of-ten boundary values under random gaps");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
